### src/cfsm_pkg.sv
// Shared types, widths and codes of the command/feedback sync monitor.
package cfsm_pkg;

	// Sizing of the value path and of the difference history.
	localparam int VALUE_BITS   = 16;
	localparam int WINDOW_DEPTH = 16;
	localparam int DIFF_W       = VALUE_BITS + 1;
	localparam int HEAD_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W        = DIFF_W + FILL_W;

	// Configuration register widths.
	localparam int WLEN_W   = 5;
	localparam int SPIKE_W  = 16;
	localparam int TICK_W   = 32;
	localparam int ERR_W    = 17;
	localparam int PROD_W   = ERR_W + FILL_W;
	localparam int CMP_W    = (PROD_W > SUM_W) ? PROD_W : SUM_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_AVERAGING_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LIMIT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT      = 3'd4;

	// Register values after reset.
	localparam logic [WLEN_W-1:0]  RST_WINDOW_LENGTH = 5'd8;
	localparam logic [SPIKE_W-1:0] RST_SPIKE_LIMIT   = 16'd256;
	localparam logic [TICK_W-1:0]  RST_SETTLE_TICKS  = 32'd1000;
	localparam logic [ERR_W-1:0]   RST_ERROR_LIMIT   = 17'd256;

	// Status codes.
	localparam logic [1:0] ST_SYNCED   = 2'd0;
	localparam logic [1:0] ST_UNSYNCED = 2'd1;
	localparam logic [1:0] ST_INDET    = 2'd2;

	// Configuration as seen by the datapath, plus the history clear pulse.
	typedef struct packed {
		logic               averaging_enable;
		logic [WLEN_W-1:0]  window_length;
		logic [SPIKE_W-1:0] spike_limit;
		logic [TICK_W-1:0]  settle_ticks;
		logic [ERR_W-1:0]   error_limit;
		logic               hist_clear;
	} cfg_t;

	// History totals after the current item has been pushed.
	typedef struct packed {
		logic [FILL_W-1:0]       fill;
		logic signed [SUM_W-1:0] sum;
	} hist_t;

endpackage

### src/cfsm_in_if.sv
// Input item channel: setpoint, measurement and tick stamp.
interface cfsm_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [cfsm_pkg::VALUE_BITS-1:0]   command_value;
	logic signed [cfsm_pkg::VALUE_BITS-1:0]   measured_value;
	logic [cfsm_pkg::TICK_W-1:0]              now_ticks;

	modport source(output valid, output command_value, output measured_value,
		output now_ticks, input ready);
	modport sink(input valid, input command_value, input measured_value,
		input now_ticks, output ready);
endinterface

### src/cfsm_out_if.sv
// Result item channel: sync status.
interface cfsm_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] sync_status;

	modport source(output valid, output sync_status, input ready);
	modport sink(input valid, input sync_status, output ready);
endinterface

### src/cfsm_cfg_if.sv
// Configuration write channel: register index and write data.
interface cfsm_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [cfsm_pkg::CFG_IDX_W-1:0]      index;
	logic [cfsm_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### src/cfsm_cfg_regs.sv
// Configuration register file with history clear on every listed write.
module cfsm_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	cfsm_cfg_if.sink          cfg,
	output cfsm_pkg::cfg_t    cfg_out
);
	import cfsm_pkg::*;

	logic               averaging_enable_q;
	logic [WLEN_W-1:0]  window_length_q;
	logic [SPIKE_W-1:0] spike_limit_q;
	logic [TICK_W-1:0]  settle_ticks_q;
	logic [ERR_W-1:0]   error_limit_q;
	logic               wr_en;
	logic               listed;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid;

	// Index decode; an index past the list writes nothing.
	always_comb begin
		unique case (cfg.index)
			REG_AVERAGING_ENABLE,
			REG_WINDOW_LENGTH,
			REG_SPIKE_LIMIT,
			REG_SETTLE_TICKS,
			REG_ERROR_LIMIT: listed = 1'b1;
			default:         listed = 1'b0;
		endcase
	end

	// Register storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			averaging_enable_q <= 1'b0;
			window_length_q    <= RST_WINDOW_LENGTH;
			spike_limit_q      <= RST_SPIKE_LIMIT;
			settle_ticks_q     <= RST_SETTLE_TICKS;
			error_limit_q      <= RST_ERROR_LIMIT;
		end else if (wr_en) begin
			unique case (cfg.index)
				REG_AVERAGING_ENABLE: averaging_enable_q <= cfg.data[0];
				REG_WINDOW_LENGTH:    window_length_q    <= cfg.data[WLEN_W-1:0];
				REG_SPIKE_LIMIT:      spike_limit_q      <= cfg.data[SPIKE_W-1:0];
				REG_SETTLE_TICKS:     settle_ticks_q     <= cfg.data[TICK_W-1:0];
				REG_ERROR_LIMIT:      error_limit_q      <= cfg.data[ERR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_out.averaging_enable = averaging_enable_q;
	assign cfg_out.window_length    = window_length_q;
	assign cfg_out.spike_limit      = spike_limit_q;
	assign cfg_out.settle_ticks     = settle_ticks_q;
	assign cfg_out.error_limit      = error_limit_q;
	assign cfg_out.hist_clear       = wr_en && listed;

endmodule

### src/cfsm_history.sv
// Ring of recent differences with running sum and fill count.
module cfsm_history (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clear,
	input  logic                                  push,
	input  logic [cfsm_pkg::WLEN_W-1:0]           window_length,
	input  logic signed [cfsm_pkg::DIFF_W-1:0]    diff,
	output cfsm_pkg::hist_t                       hist_next
);
	import cfsm_pkg::*;

	logic signed [DIFF_W-1:0] ring [WINDOW_DEPTH];
	logic [HEAD_W-1:0]        head_q;
	logic [FILL_W-1:0]        fill_q;
	logic signed [SUM_W-1:0]  sum_q;

	logic [31:0]              wlen_ext;
	logic [FILL_W-1:0]        win;
	logic                     full;
	logic [FILL_W:0]          head_ext;
	logic [FILL_W:0]          fill_ext;
	logic [HEAD_W-1:0]        oldest;
	logic signed [SUM_W-1:0]  drop;
	logic [HEAD_W-1:0]        head_inc;
	logic [FILL_W-1:0]        fill_upd;
	logic signed [SUM_W-1:0]  sum_upd;

	// Effective window, capped at the ring depth.
	assign wlen_ext = 32'(window_length);
	assign win = (wlen_ext > 32'(WINDOW_DEPTH)) ? FILL_W'(WINDOW_DEPTH) : FILL_W'(wlen_ext);

	// Location of the oldest entry, which leaves when the window is full.
	assign full     = (fill_q >= win);
	assign head_ext = (FILL_W + 1)'(head_q);
	assign fill_ext = (FILL_W + 1)'(fill_q);
	always_comb begin
		if (head_ext >= fill_ext) begin
			oldest = HEAD_W'(head_ext - fill_ext);
		end else begin
			oldest = HEAD_W'(head_ext + (FILL_W + 1)'(WINDOW_DEPTH) - fill_ext);
		end
	end

	// Totals after this push.
	assign drop     = full ? SUM_W'(ring[oldest]) : '0;
	assign sum_upd  = sum_q - drop + SUM_W'(diff);
	assign fill_upd = full ? fill_q : fill_q + 1'b1;
	assign head_inc = (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		if (win == '0) begin
			hist_next.fill = '0;
			hist_next.sum  = '0;
		end else begin
			hist_next.fill = fill_upd;
			hist_next.sum  = sum_upd;
		end
	end

	// Control state of the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (clear) begin
			head_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (push) begin
			if (win == '0) begin
				head_q <= '0;
				fill_q <= '0;
				sum_q  <= '0;
			end else begin
				head_q <= head_inc;
				fill_q <= fill_upd;
				sum_q  <= sum_upd;
			end
		end
	end

	// Ring storage; entries are read only after being written since the last clear.
	always_ff @(posedge clk) begin
		if (push && !clear && (win != '0)) begin
			ring[head_q] <= diff;
		end
	end

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("history fill count exceeds ring depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (fill_q == '0) && (sum_q == '0) && (head_q == '0))
		else $error("history not empty after clear");

	a_empty_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (sum_q == '0))
		else $error("empty history holds a nonzero sum");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !clear && (win != '0) && !full) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count did not grow on push into a partial window");

endmodule

### src/command_feedback_sync_monitor_core.sv
// Top level of the command/feedback sync monitor: item pipeline, spike timer and judgement.
//
// Usage:
//   feed   (sink)   takes one item per handshake: command_value and measured_value
//                   (signed Q8.8) and now_ticks, a wrapping free-running tick count.
//   status (source) gives one sync_status per item, in order: 0 synced,
//                   1 unsynced, 2 indeterminate.
//   cfg    (sink)   writes register index/data; always ready. Any write to a listed
//                   register empties the difference history; other indexes are ignored.
//                   Write only while no item is in flight.
//   Pipeline: an accepted item is held in the input register, and its result in the
//   result register; two register stages in all (input register, result register).
//   Throughput: one item per cycle while status is taken; the history ring, running sum
//   and spike timer all update in the single compute stage between the two registers.
//   Reset: registers take their defaults (0, 8, 256, 1000, 256), the history is empty,
//   the spike timer is disarmed and the previous setpoint is zero. No clearing pass is
//   needed; the block is ready as soon as reset is released.
//   Stall: when status is not taken, the result register holds; the input register
//   still takes one more item, and feed.ready drops only when both are full.
module command_feedback_sync_monitor_core (
	input  logic          clk,
	input  logic          arst_n,
	cfsm_in_if.sink       feed,
	cfsm_out_if.source    status,
	cfsm_cfg_if.sink      cfg
);
	import cfsm_pkg::*;

	cfg_t                        cfg_w;
	hist_t                       hist_w;

	logic                        valid_s1;
	logic signed [VALUE_BITS-1:0] cmd_s1;
	logic signed [VALUE_BITS-1:0] meas_s1;
	logic [TICK_W-1:0]           now_s1;

	logic                        out_valid_s2;
	logic [1:0]                  status_s2;

	logic signed [VALUE_BITS-1:0] last_command_q;
	logic                        spike_armed_q;
	logic [TICK_W-1:0]           spike_tick_q;

	logic                        advance;
	logic                        fire;
	logic signed [DIFF_W-1:0]    diff;
	logic signed [DIFF_W-1:0]    step;
	logic [DIFF_W-1:0]           step_mag;
	logic [DIFF_W-1:0]           diff_mag;
	logic                        spike;
	logic [TICK_W-1:0]           elapsed;
	logic                        settling;
	logic [SUM_W-1:0]            sum_mag;
	logic [PROD_W-1:0]           sum_limit;
	logic [1:0]                  status_next;

	// Configuration registers.
	cfsm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_w)
	);

	// Handshake: the input register moves on when the result register is free.
	assign advance     = !out_valid_s2 || status.ready;
	assign fire        = valid_s1 && advance;
	assign feed.ready  = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed.valid && feed.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			cmd_s1  <= feed.command_value;
			meas_s1 <= feed.measured_value;
			now_s1  <= feed.now_ticks;
		end
	end

	// Difference history.
	assign diff = DIFF_W'(meas_s1) - DIFF_W'(cmd_s1);

	cfsm_history u_hist (
		.clk           (clk),
		.arst_n        (arst_n),
		.clear         (cfg_w.hist_clear),
		.push          (fire && cfg_w.averaging_enable),
		.window_length (cfg_w.window_length),
		.diff          (diff),
		.hist_next     (hist_w)
	);

	// Spike detection against the previous setpoint, and the settle window.
	assign step     = DIFF_W'(cmd_s1) - DIFF_W'(last_command_q);
	assign step_mag = step[DIFF_W-1] ? DIFF_W'(-step) : DIFF_W'(step);
	assign spike    = step_mag > DIFF_W'(cfg_w.spike_limit);
	assign elapsed  = now_s1 - spike_tick_q;
	assign settling = spike_armed_q && (elapsed <= cfg_w.settle_ticks);

	// Error judgement: latest difference or windowed sum against limit times count.
	assign diff_mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign sum_mag   = hist_w.sum[SUM_W-1] ? SUM_W'(-hist_w.sum) : SUM_W'(hist_w.sum);
	assign sum_limit = PROD_W'(cfg_w.error_limit) * PROD_W'(hist_w.fill);

	always_comb begin
		if (spike || settling) begin
			status_next = ST_INDET;
		end else if (cfg_w.averaging_enable) begin
			if (hist_w.fill == '0) begin
				status_next = ST_INDET;
			end else if (CMP_W'(sum_mag) <= CMP_W'(sum_limit)) begin
				status_next = ST_SYNCED;
			end else begin
				status_next = ST_UNSYNCED;
			end
		end else if (32'(diff_mag) <= 32'(cfg_w.error_limit)) begin
			status_next = ST_SYNCED;
		end else begin
			status_next = ST_UNSYNCED;
		end
	end

	// Setpoint and spike timer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_command_q <= '0;
			spike_armed_q  <= 1'b0;
			spike_tick_q   <= '0;
		end else if (fire) begin
			last_command_q <= cmd_s1;
			if (spike) begin
				spike_armed_q <= 1'b1;
				spike_tick_q  <= now_s1;
			end else if (!settling) begin
				spike_armed_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
			status_s2    <= ST_SYNCED;
		end else if (fire) begin
			out_valid_s2 <= 1'b1;
			status_s2    <= status_next;
		end else if (status.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	assign status.valid       = out_valid_s2;
	assign status.sync_status = status_s2;

	a_spike_is_indet: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && spike) |=> (status_s2 == ST_INDET) && spike_armed_q)
		else $error("spike did not give indeterminate and arm the timer");

	a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(cmd_s1) && $stable(now_s1))
		else $error("input register lost an item during a stall");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid && !status.ready) |=> status.valid && $stable(status.sync_status))
		else $error("result item changed while the receiver stalled");

endmodule

### dv/command_feedback_sync_monitor_core_test.sv
// Self-checking testbench of the command/feedback sync monitor with a status predictor.
module command_feedback_sync_monitor_core_test;
	import cfsm_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 3;
	localparam int RANDOM_PHASES   = 14;
	localparam int LONG_HOLD       = 200;
	localparam int LONG_HOLD_AFTER = 250;
	localparam int MAX_REPORTS     = 10;
	localparam int DRAIN_CYCLES    = 8;
	localparam int TIMEOUT_TIME    = 5_000_000;

	// Indexes past the register list; writes to them must leave the history alone.
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_ERROR_LIMIT + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

	typedef enum logic [1:0] {
		OP_ITEM,
		OP_WRITE,
		OP_DRAIN,
		OP_PACE
	} plan_kind_e;

	typedef struct packed {
		plan_kind_e             kind;
		logic [VALUE_BITS-1:0]  command_value;
		logic [VALUE_BITS-1:0]  measured_value;
		logic [TICK_W-1:0]      now_ticks;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_DATA_W-1:0]  data;
	} plan_op_t;

	logic clk = 1'b0;
	logic arst_n;

	cfsm_in_if  feed_ch();
	cfsm_out_if status_ch();
	cfsm_cfg_if cfg_ch();

	command_feedback_sync_monitor_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_ch),
		.status (status_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	plan_op_t   stimulus_plan [$];
	logic [1:0] expected_status [$];
	int         items_sent   = 0;
	int         results_seen = 0;
	int         failures     = 0;
	logic       feed_busy    = 1'b0;
	logic       cfg_busy     = 1'b0;
	logic       burst_mode   = 1'b0;
	int         gap_left     = 0;

	// Predictor copy of the registers.
	logic               avg_mode   = 1'b0;
	logic [WLEN_W-1:0]  win_len    = RST_WINDOW_LENGTH;
	logic [SPIKE_W-1:0] spike_thr  = RST_SPIKE_LIMIT;
	logic [TICK_W-1:0]  settle_len = RST_SETTLE_TICKS;
	logic [ERR_W-1:0]   err_thr    = RST_ERROR_LIMIT;

	// Predictor copy of the state.
	logic signed [VALUE_BITS-1:0] prev_setpoint  = '0;
	logic                         settle_pending = 1'b0;
	logic [TICK_W-1:0]            settle_start   = '0;
	logic signed [DIFF_W-1:0]     diff_hist [WINDOW_DEPTH];
	logic [HEAD_W-1:0]            hist_wr    = '0;
	logic [FILL_W-1:0]            hist_count = '0;
	logic signed [SUM_W-1:0]      hist_total = '0;

	// Stimulus shaping: what the generator believes the registers hold.
	logic [SPIKE_W-1:0]           plan_spike  = RST_SPIKE_LIMIT;
	logic [TICK_W-1:0]            plan_settle = RST_SETTLE_TICKS;
	logic [ERR_W-1:0]             plan_err    = RST_ERROR_LIMIT;
	logic signed [VALUE_BITS-1:0] gen_cmd     = '0;
	logic [TICK_W-1:0]            gen_tick    = '0;
	logic [TICK_W-1:0]            gen_spike_tick = '0;

	function automatic void flush_history();
		hist_wr = '0;
		hist_count = '0;
		hist_total = '0;
	endfunction

	// Register write as the block applies it; listed registers also empty the history.
	function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_AVERAGING_ENABLE: avg_mode = data[0];
			REG_WINDOW_LENGTH:    win_len = data[WLEN_W-1:0];
			REG_SPIKE_LIMIT:      spike_thr = data[SPIKE_W-1:0];
			REG_SETTLE_TICKS:     settle_len = data[TICK_W-1:0];
			REG_ERROR_LIMIT:      err_thr = data[ERR_W-1:0];
			default:              return;
		endcase
		flush_history();
	endfunction

	// Status that one accepted item should produce; advances the predictor state.
	function automatic logic [1:0] predict_status(
		input logic signed [VALUE_BITS-1:0] cmd,
		input logic signed [VALUE_BITS-1:0] meas,
		input logic [TICK_W-1:0]            now
	);
		logic signed [DIFF_W-1:0] diff;
		logic signed [DIFF_W-1:0] cmd_step;
		logic [TICK_W-1:0]        elapsed;
		longint                   magnitude;
		int                       win;
		int                       oldest;
		logic [1:0]               verdict;

		diff = {meas[VALUE_BITS-1], meas} - {cmd[VALUE_BITS-1], cmd};
		cmd_step = {cmd[VALUE_BITS-1], cmd} - {prev_setpoint[VALUE_BITS-1], prev_setpoint};
		prev_setpoint = cmd;

		// While averaging, every item pushes its difference, dropping the oldest ones.
		if (avg_mode) begin
			win = (win_len > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(win_len);
			if (win == 0) begin
				flush_history();
			end else begin
				while (int'(hist_count) >= win) begin
					oldest = (int'(hist_wr) + WINDOW_DEPTH - int'(hist_count) % WINDOW_DEPTH)
						% WINDOW_DEPTH;
					hist_total = hist_total - diff_hist[oldest];
					hist_count = hist_count - 1'b1;
				end
				diff_hist[hist_wr] = diff;
				hist_total = hist_total + diff;
				hist_wr = HEAD_W'((int'(hist_wr) + 1) % WINDOW_DEPTH);
				hist_count = hist_count + 1'b1;
			end
		end

		// A spike restarts the settle timer; otherwise judge once it has run out.
		magnitude = (cmd_step < 0) ? -longint'(cmd_step) : longint'(cmd_step);
		if (magnitude > longint'(spike_thr)) begin
			settle_start = now;
			settle_pending = 1'b1;
			verdict = ST_INDET;
		end else begin
			elapsed = now - settle_start;
			if (settle_pending && elapsed <= settle_len) begin
				verdict = ST_INDET;
			end else begin
				settle_pending = 1'b0;
				if (!avg_mode) begin
					magnitude = (diff < 0) ? -longint'(diff) : longint'(diff);
					verdict = (magnitude <= longint'(err_thr)) ? ST_SYNCED : ST_UNSYNCED;
				end else if (hist_count == 0) begin
					verdict = ST_INDET;
				end else begin
					magnitude = (hist_total < 0) ? -longint'(hist_total) : longint'(hist_total);
					verdict = (magnitude <= longint'(err_thr) * longint'(hist_count)) ?
						ST_SYNCED : ST_UNSYNCED;
				end
			end
		end
		return verdict;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_failure(input string what);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("%s", what);
	endtask

	task automatic queue_item(input int cmd, input int meas, input logic [TICK_W-1:0] ticks);
		plan_op_t op;
		op = '0;
		op.kind = OP_ITEM;
		op.command_value = VALUE_BITS'(cmd);
		op.measured_value = VALUE_BITS'(meas);
		op.now_ticks = ticks;
		stimulus_plan.insert(stimulus_plan.size(), op);
	endtask

	task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		plan_op_t op;
		op = '0;
		op.kind = OP_WRITE;
		op.index = idx;
		op.data = data;
		stimulus_plan.insert(stimulus_plan.size(), op);
		case (idx)
			REG_SPIKE_LIMIT:  plan_spike = data[SPIKE_W-1:0];
			REG_SETTLE_TICKS: plan_settle = data[TICK_W-1:0];
			REG_ERROR_LIMIT:  plan_err = data[ERR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_control(input plan_kind_e kind, input logic flag);
		plan_op_t op;
		op = '0;
		op.kind = kind;
		op.data[0] = flag;
		stimulus_plan.insert(stimulus_plan.size(), op);
	endtask

	// Mostly small setpoint moves with errors near the limit, some spikes and settle edges.
	task automatic queue_random_item();
		int r;
		int lim;
		int pick;
		int delta;
		int meas;

		r = $urandom_range(0, 99);
		if (r < 4)
			gen_tick = $urandom;
		else if (r < 16)
			gen_tick = gen_spike_tick + plan_settle + $urandom_range(0, 1);
		else
			gen_tick = gen_tick + $urandom_range(0, 63);

		r = $urandom_range(0, 99);
		if (r < 8) begin
			delta = int'(plan_spike) + 1 + $urandom_range(0, 255);
			gen_cmd = VALUE_BITS'(int'(gen_cmd) + ($urandom_range(0, 1) ? delta : -delta));
			gen_spike_tick = gen_tick;
		end else if (r < 12) begin
			delta = int'(plan_spike);
			gen_cmd = VALUE_BITS'(int'(gen_cmd) + ($urandom_range(0, 1) ? delta : -delta));
		end else if (r < 16) begin
			gen_cmd = VALUE_BITS'($urandom);
			gen_spike_tick = gen_tick;
		end else begin
			lim = (plan_spike > 32) ? 32 : int'(plan_spike);
			pick = $urandom_range(0, 2 * lim);
			gen_cmd = VALUE_BITS'(int'(gen_cmd) + pick - lim);
		end

		r = $urandom_range(0, 99);
		lim = (plan_err > 4000) ? 4000 : int'(plan_err);
		if (r < 45) begin
			pick = $urandom_range(0, 2 * lim);
			meas = int'(gen_cmd) + pick - lim;
		end else if (r < 70) begin
			delta = int'(plan_err) + $urandom_range(0, 1);
			meas = int'(gen_cmd) + ($urandom_range(0, 1) ? delta : -delta);
		end else if (r < 85) begin
			delta = int'(plan_err) + $urandom_range(0, 300);
			meas = int'(gen_cmd) + ($urandom_range(0, 1) ? delta : -delta);
		end else begin
			meas = $urandom;
		end
		queue_item(gen_cmd, meas, gen_tick);
	endtask

	// Item and register driver, fed from the plan queue.
	always @(posedge clk) begin : feed_driver
		plan_op_t op;
		if (arst_n) begin
			if (feed_ch.valid && feed_ch.ready) begin
				expected_status.insert(expected_status.size(),
					predict_status(feed_ch.command_value, feed_ch.measured_value,
					feed_ch.now_ticks));
				items_sent++;
				feed_busy = 1'b0;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				write_register(cfg_ch.index, cfg_ch.data);
				cfg_busy = 1'b0;
			end
			if (!feed_busy && !cfg_busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stimulus_plan.size() > 0) begin
					op = stimulus_plan[0];
					case (op.kind)
						OP_ITEM: begin
							stimulus_plan.delete(0);
							feed_ch.command_value <= op.command_value;
							feed_ch.measured_value <= op.measured_value;
							feed_ch.now_ticks <= op.now_ticks;
							feed_busy = 1'b1;
							gap_left = burst_mode ? 0 : pick_gap();
						end
						// Registers change only with no item in flight.
						OP_WRITE: begin
							if (items_sent == results_seen) begin
								stimulus_plan.delete(0);
								cfg_ch.index <= op.index;
								cfg_ch.data <= op.data;
								cfg_busy = 1'b1;
							end
						end
						OP_DRAIN: begin
							if (items_sent == results_seen)
								stimulus_plan.delete(0);
						end
						default: begin
							stimulus_plan.delete(0);
							burst_mode = op.data[0];
						end
					endcase
				end
			end
			feed_ch.valid <= feed_busy;
			cfg_ch.valid <= cfg_busy;
		end
	end

	// Status monitor and receiver back-pressure.
	int   hold_left      = 0;
	int   rx_mode_left   = 0;
	logic rx_quiet       = 1'b0;
	logic long_hold_done = 1'b0;

	always @(posedge clk) begin : status_monitor
		logic [1:0] want;
		logic       next_ready;
		if (arst_n) begin
			if (status_ch.valid && status_ch.ready) begin
				if (expected_status.size() == 0) begin
					report_failure($sformatf("unexpected status item %0d: got %0d",
						results_seen, status_ch.sync_status));
				end else begin
					want = expected_status[0];
					expected_status.delete(0);
					if (status_ch.sync_status !== want)
						report_failure($sformatf("status item %0d: expected %0d, got %0d",
							results_seen, want, status_ch.sync_status));
				end
				results_seen <= results_seen + 1;
			end

			// Alternate stretches of random stalls with stretches of none.
			if (rx_mode_left == 0) begin
				rx_quiet = ($urandom_range(0, 3) == 0);
				rx_mode_left = $urandom_range(100, 300);
			end else begin
				rx_mode_left--;
			end

			// One long hold-off while the sender keeps offering items.
			if (!long_hold_done && results_seen >= LONG_HOLD_AFTER && feed_ch.valid) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end

			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (rx_quiet || $urandom_range(0, 3) != 0) begin
				next_ready = 1'b1;
			end else begin
				next_ready = 1'b0;
				hold_left = pick_gap();
			end
			status_ch.ready <= next_ready;
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin : stimulus_and_end
		int                   items;
		int                   r;
		logic                 write_every;
		logic [CFG_DATA_W-1:0] value;

		arst_n = 1'b0;
		feed_ch.valid = 1'b0;
		feed_ch.command_value = '0;
		feed_ch.measured_value = '0;
		feed_ch.now_ticks = '0;
		status_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		foreach (diff_hist[i])
			diff_hist[i] = '0;

		// Latest-value mode at reset settings: error edges and value extremes.
		queue_item(0, 0, 32'd0);
		queue_item(256, 512, 32'd10);
		queue_item(256, 513, 32'd20);
		queue_item(-32768, 32767, 32'd30);
		queue_item(-32768, 32767, 32'd1030);
		queue_item(-32768, 32767, 32'd1031);
		// Settle time measured across the tick wrap.
		queue_item(32767, -32768, 32'hFFFF_FF00);
		queue_item(32767, -32768, 32'h0000_02E9);
		queue_item(32511, 32511, 32'd100);
		// A second spike restarts the settle timer.
		queue_item(0, 0, 32'd5000);
		queue_item(300, 300, 32'd5600);
		queue_item(300, 300, 32'd6200);
		queue_item(300, 300, 32'd6601);
		queue_item(300, 44, 32'd6700);
		queue_item(300, 43, 32'd6800);
		queue_item(-1, -32768, 32'hFFFF_FFFF);

		// Averaging with an empty window answers indeterminate.
		queue_write(REG_AVERAGING_ENABLE, 32'hFFFF_FFF1);
		queue_write(REG_WINDOW_LENGTH, 32'h0000_0000);
		queue_item(-1, -1, 32'h0001_0000);
		// Window of three: the oldest difference falls out of the sum.
		queue_write(REG_WINDOW_LENGTH, 32'hABCD_EF03);
		queue_item(-1, 299, 32'h0001_0100);
		queue_item(-1, -101, 32'h0001_0110);
		queue_item(-1, 99, 32'h0001_0120);
		queue_item(-1, 699, 32'h0001_0130);
		queue_item(-1, 799, 32'h0001_0140);
		// A write past the register list keeps the history.
		queue_write(REG_LAST_UNUSED, 32'h5555_AAAA);
		queue_item(-1, -1, 32'h0001_0150);
		// Zero settle time, widest error limit, window clipped to the ring depth.
		queue_write(REG_SPIKE_LIMIT, 32'h5A5A_0040);
		queue_write(REG_SETTLE_TICKS, 32'h0000_0000);
		queue_write(REG_ERROR_LIMIT, 32'hFFFF_FFFF);
		queue_write(REG_WINDOW_LENGTH, 32'h0000_001F);
		queue_item(-1, -1, 32'h0001_0200);
		queue_item(64, 64, 32'h0001_0210);
		queue_item(64, 64, 32'h0001_0210);
		queue_item(64, 32767, 32'h0001_0211);
		gen_cmd = 64;
		gen_tick = 32'h0001_0211;
		gen_spike_tick = 32'h0001_0210;

		// Random phases, each under its own register settings.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_every = (phase == 0) || ($urandom_range(0, 4) == 0);
			queue_control(OP_PACE, (phase == 1) || ($urandom_range(0, 3) == 0));
			for (int ri = int'(REG_AVERAGING_ENABLE); ri <= int'(REG_ERROR_LIMIT); ri++) begin
				if (write_every || $urandom_range(0, 99) < 60) begin
					r = $urandom_range(0, 99);
					case (CFG_IDX_W'(ri))
						REG_AVERAGING_ENABLE: value = ($urandom & ~32'h1) | $urandom_range(0, 1);
						REG_WINDOW_LENGTH: begin
							if (r < 15)
								value = 0;
							else if (r < 30)
								value = WINDOW_DEPTH;
							else if (r < 40)
								value = $urandom_range(WINDOW_DEPTH + 1, 31);
							else if (r < 55)
								value = 1;
							else
								value = $urandom_range(2, WINDOW_DEPTH - 1);
							value = ($urandom & ~32'h1F) | value;
						end
						REG_SPIKE_LIMIT: begin
							if (r < 10)
								value = 0;
							else if (r < 20)
								value = 32'hFFFF;
							else if (r < 60)
								value = $urandom_range(64, 1024);
							else
								value = $urandom_range(0, 32'hFFFF);
							value = ($urandom & 32'hFFFF_0000) | value;
						end
						REG_SETTLE_TICKS: begin
							if (r < 10)
								value = 0;
							else if (r < 15)
								value = 1;
							else if (r < 22)
								value = 32'hFFFF_FFFF;
							else if (r < 70)
								value = $urandom_range(10, 600);
							else
								value = $urandom_range(600, 5000);
						end
						default: begin
							if (r < 10)
								value = 0;
							else if (r < 20)
								value = 32'h1_FFFF;
							else if (r < 70)
								value = $urandom_range(16, 1024);
							else
								value = $urandom_range(0, 32'h1_FFFF);
							value = ($urandom & 32'hFFFE_0000) | value;
						end
					endcase
					queue_write(CFG_IDX_W'(ri), value);
				end
			end
			if ($urandom_range(0, 5) == 0)
				queue_write(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), $urandom);
			items = $urandom_range(35, 65);
			for (int k = 0; k < items; k++) begin
				// Midway through one phase the sender waits for every status to return.
				if (phase == 2 && k == items / 2)
					queue_control(OP_DRAIN, 1'b0);
				queue_random_item();
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the plan to run dry and every status to come back.
		while (stimulus_plan.size() != 0 || feed_busy || cfg_busy)
			@(negedge clk);
		while (items_sent != results_seen)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_status.size() != 0)
			report_failure($sformatf("%0d status items never arrived", expected_status.size()));
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#TIMEOUT_TIME;
		$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
src/cfsm_pkg.sv
src/cfsm_in_if.sv
src/cfsm_out_if.sv
src/cfsm_cfg_if.sv
src/cfsm_cfg_regs.sv
src/cfsm_history.sv
src/command_feedback_sync_monitor_core.sv
dv/command_feedback_sync_monitor_core_test.sv
